@@ hw/rtl/dsit_pkg.sv @@
// ----------------------------------------------------------------------------
// dsit_pkg
// Shared types and constants for the descending sorted insert table.
// ----------------------------------------------------------------------------
package dsit_pkg;

  // Table geometry.
  localparam int unsigned CAPACITY = 128;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = $clog2(CAPACITY + 1);

  // Fixed field widths of the item interface.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned COUNT_W = 8;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_BEYOND   = 3'd4
  } dsit_status_e;

  // Input item.
  typedef struct packed {
    logic                      req_type;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index;
  } dsit_in_t;

  // Result item.
  typedef struct packed {
    dsit_status_e              status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        count;
  } dsit_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load;
    logic         scan_step;
    logic         shift_init;
    logic         shift_step;
    logic         write_new;
    logic         rd_issue;
    logic         out_load;
    dsit_status_e code;
  } dsit_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic full;
    logic idx_ok;
    logic scan_stop;
    logic scan_dup;
    logic scan_end;
    logic shift_done;
    logic out_free;
  } dsit_sts_t;

endpackage

@@ hw/rtl/dsit_dp.sv @@
// ----------------------------------------------------------------------------
// dsit_dp
// Datapath: entry memory, fill count, scan and shift pointers, result register.
// ----------------------------------------------------------------------------
module dsit_dp import dsit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dsit_in_t  in_data_i,
  input  dsit_cmd_t cmd_i,
  output dsit_sts_t sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output dsit_out_t out_data_o
);

  // Entry storage and its registered read port.
  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_q;

  // Captured item.
  logic                     req_q;
  logic signed [DATA_W-1:0] val_q;
  logic [INDEX_W-1:0]       idx_q;

  // Control registers.
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] raddr_q, raddr_d;
  logic          rvld_q, rvld_d;
  logic          ren;

  // Write port.
  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;

  // Result register.
  logic      out_vld_q;
  dsit_out_t out_q;

  logic less;

  // The value belongs after the entry just read while it is smaller.
  assign less = (val_q < rd_q);

  // Status toward the controller.
  always_comb begin
    sts_o.is_read    = (req_q == REQ_READ);
    sts_o.full       = (cnt_q == CW'(CAPACITY));
    sts_o.idx_ok     = (CW'(idx_q) < cnt_q);
    sts_o.scan_stop  = rvld_q && !less;
    sts_o.scan_dup   = rvld_q && (rd_q == val_q);
    sts_o.scan_end   = !rvld_q && (ptr_q == cnt_q);
    sts_o.shift_done = !rvld_q && (ptr_q == pos_q);
    sts_o.out_free   = !out_vld_q || !out_stall_i;
  end

  // Read address and pointer sequencing; one memory read per cycle.
  always_comb begin
    ren     = 1'b0;
    raddr_d = raddr_q;
    ptr_d   = ptr_q;
    rvld_d  = rvld_q;
    pos_d   = pos_q;
    if (cmd_i.load) begin
      ptr_d  = '0;
      rvld_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (ptr_q < cnt_q) begin
        ren     = 1'b1;
        raddr_d = ptr_q;
        ptr_d   = ptr_q + CW'(1);
        rvld_d  = 1'b1;
      end else begin
        rvld_d = 1'b0;
      end
    end
    if (cmd_i.shift_init) begin
      ptr_d  = cnt_q;
      rvld_d = 1'b0;
      pos_d  = rvld_q ? raddr_q : cnt_q;
    end
    if (cmd_i.shift_step) begin
      if (ptr_q > pos_q) begin
        ren     = 1'b1;
        raddr_d = ptr_q - CW'(1);
        ptr_d   = ptr_q - CW'(1);
        rvld_d  = 1'b1;
      end else begin
        rvld_d = 1'b0;
      end
    end
    if (cmd_i.rd_issue) begin
      ren     = 1'b1;
      raddr_d = CW'(idx_q);
    end
  end

  // Write port: moves an entry one place down, or places the new value.
  always_comb begin
    we    = (cmd_i.shift_step && rvld_q) || cmd_i.write_new;
    waddr = cmd_i.write_new ? pos_q[AW-1:0] : AW'(raddr_q + CW'(1));
    wdata = cmd_i.write_new ? val_q : rd_q;
  end

  // The fill count grows by one on each placed value.
  assign cnt_d = cmd_i.write_new ? cnt_q + CW'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ptr_q   <= '0;
      pos_q   <= '0;
      raddr_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      pos_q   <= pos_d;
      raddr_q <= raddr_d;
      rvld_q  <= rvld_d;
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i.req_type;
      val_q <= in_data_i.value;
      idx_q <= in_data_i.index;
    end
  end

  // Entry memory.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rd_q <= mem[raddr_d[AW-1:0]];
    end
  end

  // Result register; holds until the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status     <= cmd_i.code;
      out_q.read_value <= (cmd_i.code == ST_READ_OK) ? rd_q : '0;
      out_q.count      <= COUNT_W'(cnt_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/dsit_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsit_ctrl
// Controller: sequences decode, scan, shift, read and result handoff.
// ----------------------------------------------------------------------------
module dsit_ctrl import dsit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dsit_sts_t sts_i,
  output dsit_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_RDWAIT,
    S_RESP
  } state_e;

  state_e       state_q, state_d;
  dsit_status_e code_q, code_d;

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    code_d           = code_q;
    cmd_o            = '0;
    cmd_o.code       = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.is_read && sts_i.idx_ok) begin
          cmd_o.rd_issue = 1'b1;
          code_d         = ST_READ_OK;
          state_d        = S_RDWAIT;
        end else if (sts_i.is_read) begin
          code_d  = ST_BEYOND;
          state_d = S_RESP;
        end else if (sts_i.full) begin
          code_d  = ST_FULL;
          state_d = S_RESP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts_i.scan_stop && sts_i.scan_dup) begin
          code_d  = ST_DUP;
          state_d = S_RESP;
        end else if (sts_i.scan_stop || sts_i.scan_end) begin
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          cmd_o.write_new = 1'b1;
          code_d          = ST_INSERTED;
          state_d         = S_RESP;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_RDWAIT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and status code registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ hw/rtl/descending_sorted_insert_table.sv @@
// ----------------------------------------------------------------------------
// descending_sorted_insert_table
// Table of signed words kept in strictly descending order with a fill count.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result per item. An
// insert scans the entry memory, which has one read and one write port,
// from the front, one entry per cycle, for the first entry not greater than
// the value, then moves the later entries down one place, one per cycle, and
// writes the value. A full table rejects an insert, and a value already held
// is rejected as a duplicate. The memory's one read and one write per cycle
// set the pace of the scan and the shift. The next item is taken once the
// result has moved into the output register, even while that result still
// waits for its transfer.
module descending_sorted_insert_table import dsit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dsit_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dsit_out_t out_data_o
);

  dsit_cmd_t cmd;
  dsit_sts_t sts;

  // Sequencer.
  dsit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and result path.
  dsit_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Only a successful read carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_READ_OK) |-> out_data_o.read_value == '0)
    else $error("read_value nonzero on a result that is not a read");

  // A full rejection reports a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |->
      out_data_o.count == COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  // After an accepted item the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("controller did not go busy after a transfer");

  // The new value is never placed while entries are still moving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_new |-> !cmd.shift_step && sts.shift_done)
    else $error("value placed before the shift finished");

endmodule

@@ dv/descending_sorted_insert_table_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// descending_sorted_insert_table_test
// Self-checking testbench for the descending sorted insert table.
// ----------------------------------------------------------------------------
// A table model in the testbench tracks the held words and the fill count, and
// it predicts the result of every accepted transfer. Directed items cover the
// extreme values, inserts at the front and at the back, duplicates, and reads
// beyond the count. Random traffic then fills the table slowly, with
// duplicates and near neighbors mixed in. A long hold on the result side
// backs the block up. The last phase works on the full table.
// ----------------------------------------------------------------------------
module descending_sorted_insert_table_test;
  import dsit_pkg::*;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  dsit_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  dsit_out_t out_data_o;

  // Table model state.
  logic signed [DATA_W-1:0] held_words [CAPACITY];
  int unsigned              held_count = 0;

  // Results still owed by the block, oldest first.
  dsit_out_t   awaited_results [$];
  int unsigned mismatch_count = 0;

  // Idle control shared by the sender and the receiver.
  bit          calm      = 1'b0;
  int unsigned hold_left = 0;

  descending_sorted_insert_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Applies one item to the table model and returns the result it owes.
  function automatic dsit_out_t predict_table_result(dsit_in_t item);
    dsit_out_t   res;
    int unsigned pos;
    res            = '0;
    res.read_value = '0;
    if (item.req_type == REQ_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && $signed(item.value) < $signed(held_words[pos])) pos++;
        if (pos < held_count && held_words[pos] == item.value) begin
          res.status = ST_DUP;
        end else begin
          for (int k = held_count; k > pos; k--) held_words[k] = held_words[k-1];
          held_words[pos] = item.value;
          held_count++;
          res.status = ST_INSERTED;
        end
      end
    end else if (item.index < held_count) begin
      res.status     = ST_READ_OK;
      res.read_value = held_words[item.index];
    end else begin
      res.status = ST_BEYOND;
    end
    res.count = held_count[COUNT_W-1:0];
    return res;
  endfunction

  // Mostly short idle runs, now and then a long one.
  function automatic int unsigned pick_idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // The unused field of each item gets random content.
  function automatic dsit_in_t make_insert(logic signed [DATA_W-1:0] value);
    dsit_in_t item;
    item.req_type = REQ_INSERT;
    item.value    = value;
    item.index    = INDEX_W'($urandom_range(0, 127));
    return item;
  endfunction

  function automatic dsit_in_t make_read(int unsigned index);
    dsit_in_t item;
    item.req_type = REQ_READ;
    item.value    = $urandom();
    item.index    = index[INDEX_W-1:0];
    return item;
  endfunction

  // Insert values: held words, their neighbors, a narrow band and the full range.
  function automatic logic signed [DATA_W-1:0] pick_insert_value();
    int unsigned roll;
    int unsigned slot;
    roll = $urandom_range(0, 99);
    slot = (held_count > 0) ? $urandom_range(0, held_count - 1) : 0;
    if (held_count > 0 && roll < 20) return held_words[slot];
    if (held_count > 0 && roll < 35) return held_words[slot] + ($urandom_range(0, 1) ? 1 : -1);
    if (roll < 50) return $signed(32'($urandom_range(0, 32))) - 16;
    return $urandom();
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offers one item and waits for its transfer.
  task automatic send_item(dsit_in_t item);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 1)) ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(predict_table_result(item));
  endtask

  task automatic check_result(dsit_out_t got);
    dsit_out_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, status %0d", got.status));
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.read_value !== want.read_value)
      report_mismatch($sformatf("read_value %0d, expected %0d", got.read_value,
                                want.read_value));
    if (got.count !== want.count)
      report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
  endtask

  // Result side: checks each transfer and stalls at random or on a hold.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
          stall_left = pick_idle_len();
        if (stall_left > 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Extremes, front and back inserts, duplicates and reads past the count.
  task automatic test_directed_edges();
    send_item(make_read(0));
    send_item(make_read(127));
    send_item(make_insert(32'sd0));
    send_item(make_insert(32'sh7FFF_FFFF));
    send_item(make_insert(32'sh8000_0000));
    send_item(make_insert(-32'sd1));
    send_item(make_insert(32'sd1));
    send_item(make_insert(32'sh7FFF_FFFF));
    send_item(make_insert(32'sh8000_0000));
    send_item(make_insert(32'sd0));
    send_item(make_read(0));
    send_item(make_read(4));
    send_item(make_read(5));
    send_item(make_read(127));
    send_item(make_insert(32'sh7FFF_FFFE));
    send_item(make_insert(32'sh8000_0001));
    send_item(make_read(1));
    send_item(make_read(6));
    send_item(make_read(7));
  endtask

  // Mostly reads, with about one insert in five.
  task automatic test_random_mix(int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 20) begin
        send_item(make_insert(pick_insert_value()));
      end else if (held_count > 0 && $urandom_range(0, 1)) begin
        send_item(make_read($urandom_range(0, held_count - 1)));
      end else begin
        send_item(make_read($urandom_range(0, 127)));
      end
    end
    calm = 1'b0;
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_input_backpressure();
    calm      = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0) send_item(make_insert(pick_insert_value()));
      else send_item(make_read($urandom_range(0, 127)));
    end
    calm = 1'b0;
  endtask

  // Fill the table, then rejected inserts and reads at random positions.
  task automatic test_full_table();
    while (held_count < CAPACITY) send_item(make_insert(pick_insert_value()));
    send_item(make_insert(held_words[0]));
    send_item(make_insert(held_words[CAPACITY-1] - 1));
    send_item(make_read(0));
    send_item(make_read(127));
    for (int i = 0; i < 250; i++) begin
      if ($urandom_range(0, 99) < 40) send_item(make_insert(pick_insert_value()));
      else send_item(make_read($urandom_range(0, 127)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_random_mix(400);
    test_input_backpressure();
    test_random_mix(450);
    test_full_table();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
